// File: rtl/core/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and codes of the button gesture detector
// Event codes, register indexes and the queue entry that carries the
// events of one poll from the front end to the back end.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CODE_W = 3;
    localparam int MAX_EV = 3;
    localparam int IDX_W  = 4;

    localparam logic [CODE_W-1:0] EV_PRESSED  = 3'd0;
    localparam logic [CODE_W-1:0] EV_RELEASED = 3'd1;
    localparam logic [CODE_W-1:0] EV_CLICK    = 3'd2;
    localparam logic [CODE_W-1:0] EV_DOUBLE   = 3'd3;
    localparam logic [CODE_W-1:0] EV_LONG     = 3'd4;

    localparam logic [IDX_W-1:0] REG_POLARITY_LOW = 4'd0;
    localparam logic [IDX_W-1:0] REG_SETTLE_MS    = 4'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_MS      = 4'd2;
    localparam logic [IDX_W-1:0] REG_PAIR_WINDOW  = 4'd3;

    // Events of one poll, in firing order in the low slots.
    typedef struct packed {
        logic [1:0]                    count;
        logic                          held;
        logic [MAX_EV-1:0][CODE_W-1:0] codes;
    } ev_entry_t;

endpackage

// File: rtl/core/bgd_front.sv
// ----------------------------------------------------------------------------
// bgd_front: poll classifier
// Holds the configuration and the gesture state, takes one poll a cycle
// while the queue is not full, and turns it into a queue entry with up to three events.
// ----------------------------------------------------------------------------
module bgd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bgd_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bgd_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              poll_valid,
    output logic                              poll_ready,
    input  logic                              pin_level,
    input  logic [bgd_pkg::TIME_W-1:0]        time_ms,
    input  logic                              q_full,
    output logic                              push,
    output bgd_pkg::ev_entry_t                push_entry
);

    logic                        polarity_low_reg;
    logic [bgd_pkg::CFG_W-1:0]   settle_ms_reg, hold_ms_reg, pair_window_reg;
    logic                        primed_reg, sampled_reg, stable_reg, long_fired_reg;
    logic                        click_waiting_reg;
    logic [bgd_pkg::TIME_W-1:0]  change_time_reg, press_time_reg, click_time_reg;

    logic                        accept, pressed, chg, settled, edge_hit, rising, falling;
    logic [bgd_pkg::TIME_W-1:0]  diff_chg, diff_press, diff_click;
    logic                        settle_ok, hold_ok, pair_ok, short_press;
    logic                        dbl_ev, rec_click, long_ev, click_ev;
    logic                        stable_next, lf_edge, cw_after;
    logic                        press_old_hold, click_old_pair;
    logic [3:0]                  cand_hit;
    logic [3:0][bgd_pkg::CODE_W-1:0] cand_code;
    logic [1:0]                  n_ev;
    bgd_pkg::ev_entry_t          entry;

    assign accept     = poll_valid && !q_full;
    assign poll_ready = !q_full;

    always_comb begin
        pressed    = polarity_low_reg ? !pin_level : pin_level;
        chg        = pressed != sampled_reg;
        diff_chg   = time_ms - change_time_reg;
        diff_press = time_ms - press_time_reg;
        diff_click = time_ms - click_time_reg;
        settle_ok  = diff_chg >= {16'd0, settle_ms_reg};
        hold_ok    = diff_press >= {16'd0, hold_ms_reg};
        pair_ok    = diff_click >= {16'd0, pair_window_reg};
        // A level change this poll restarts the settle timer at zero.
        settled    = chg ? (settle_ms_reg == '0) : settle_ok;
        edge_hit   = settled && (pressed != stable_reg);
        rising     = edge_hit && pressed;
        falling    = edge_hit && !pressed;

        short_press = !long_fired_reg && !hold_ok;
        dbl_ev      = falling && short_press && click_waiting_reg && !pair_ok;
        rec_click   = falling && short_press && !(click_waiting_reg && !pair_ok);

        stable_next = edge_hit ? pressed : stable_reg;
        lf_edge     = rising ? 1'b0 : long_fired_reg;
        // A press this poll restarts the hold timer at zero.
        press_old_hold = rising ? (hold_ms_reg == '0) : hold_ok;
        long_ev     = settled && stable_next && !lf_edge && press_old_hold;

        cw_after    = dbl_ev ? 1'b0 : (rec_click ? 1'b1 : click_waiting_reg);
        click_old_pair = rec_click ? (pair_window_reg == '0) : pair_ok;
        click_ev    = cw_after && click_old_pair;

        cand_hit  = {click_ev, long_ev, dbl_ev, edge_hit};
        cand_code = {bgd_pkg::EV_CLICK, bgd_pkg::EV_LONG, bgd_pkg::EV_DOUBLE,
                     (pressed ? bgd_pkg::EV_PRESSED : bgd_pkg::EV_RELEASED)};

        // Append fired events in order; at most three can fire together.
        entry = '0;
        n_ev  = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_hit[i] && n_ev != 2'd3) begin
                entry.codes[n_ev] = cand_code[i];
                n_ev = n_ev + 2'd1;
            end
        end
        entry.count = n_ev;
        entry.held  = stable_next;
    end

    assign push       = accept && primed_reg && (n_ev != 2'd0);
    assign push_entry = entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_low_reg  <= 1'b1;
            settle_ms_reg     <= 16'd20;
            hold_ms_reg       <= 16'd1000;
            pair_window_reg   <= 16'd300;
            primed_reg        <= 1'b0;
            sampled_reg       <= 1'b0;
            stable_reg        <= 1'b0;
            long_fired_reg    <= 1'b0;
            click_waiting_reg <= 1'b0;
            change_time_reg   <= '0;
            press_time_reg    <= '0;
            click_time_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bgd_pkg::REG_POLARITY_LOW: polarity_low_reg <= cfg_wdata[0];
                    bgd_pkg::REG_SETTLE_MS:    settle_ms_reg    <= cfg_wdata;
                    bgd_pkg::REG_HOLD_MS:      hold_ms_reg      <= cfg_wdata;
                    bgd_pkg::REG_PAIR_WINDOW:  pair_window_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                if (!primed_reg) begin
                    primed_reg      <= 1'b1;
                    sampled_reg     <= pressed;
                    stable_reg      <= pressed;
                    change_time_reg <= time_ms;
                end else begin
                    if (chg) begin
                        sampled_reg     <= pressed;
                        change_time_reg <= time_ms;
                    end
                    stable_reg        <= stable_next;
                    long_fired_reg    <= long_ev ? 1'b1 : lf_edge;
                    click_waiting_reg <= click_ev ? 1'b0 : cw_after;
                    if (rising)    press_time_reg <= time_ms;
                    if (rec_click) click_time_reg <= time_ms;
                end
            end
        end
    end

endmodule

// File: rtl/core/bgd_queue.sv
// ----------------------------------------------------------------------------
// bgd_queue: event entry queue
// Small flop queue between classifier and event drain.
// ----------------------------------------------------------------------------
module bgd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  bgd_pkg::ev_entry_t            push_entry,
    input  logic                          pop,
    output bgd_pkg::ev_entry_t            head,
    output logic                          empty,
    output logic                          full,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    bgd_pkg::ev_entry_t mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               do_push, do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == CW'(DEPTH);
    assign count   = count_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CW'(1);
        end
    end

endmodule

// File: rtl/core/bgd_back.sv
// ----------------------------------------------------------------------------
// bgd_back: event drain
// Steps through the events of the head entry, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bgd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bgd_pkg::ev_entry_t    head,
    input  logic                  empty,
    output logic                  pop,
    output logic [1:0]            ev_idx,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    logic [1:0]                   idx_reg, idx_next;
    logic                         valid_reg;
    logic [bgd_pkg::CODE_W-1:0]   code_reg;
    logic                         held_reg, last_reg;
    logic                         load, last_ev;

    assign load    = !empty && (!valid_reg || m_tready);
    assign last_ev = (idx_reg + 2'd1) == head.count;
    assign pop     = load && last_ev;
    assign idx_next = load ? (last_ev ? 2'd0 : idx_reg + 2'd1) : idx_reg;
    assign ev_idx  = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load)          valid_reg <= 1'b1;
            else if (m_tready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= head.codes[idx_reg];
            held_reg <= head.held;
            last_reg <= last_ev;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, held_reg, code_reg};
    assign m_tlast  = last_reg;

endmodule

// File: rtl/core/button_gesture_detector_unit.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_unit: debounced button gestures from polls
// Path: an accepted poll's events pass through the queue and then the output register to m_.
// Throughput: one poll per cycle while the queue is not full; the drain steps
// one event per cycle while m_ is not stalled (three events per poll at most).
// Reset (aresetn low, synchronous): registers return to their defaults,
// gesture state clears, queue and output empty; the first poll only primes.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port
    input  logic                         cfg_wr_en,
    input  logic [bgd_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bgd_pkg::CFG_W-1:0]    cfg_wdata,
    // Poll input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // [0] pin_level, [32:1] time_ms, rest 0
    // Event output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [2:0] event_code, [3] held_now, rest 0
    output logic                         m_tlast    // run_end: last event of a poll
);

    logic                             push, pop, q_empty, q_full;
    bgd_pkg::ev_entry_t               push_entry, head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic [1:0]                       ev_idx;

    // Front end: classify each poll and push its event list.
    bgd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .poll_valid (s_tvalid),
        .poll_ready (s_tready),
        .pin_level  (s_tdata[0]),
        .time_ms    (s_tdata[32:1]),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouple polls from event drain so each side can stall alone.
    bgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full),
        .count      (q_count)
    );

    // Back end: drain one event per cycle, while the output is not stalled, into the output register.
    bgd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .ev_idx   (ev_idx),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Queue never overfills.
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // Every pushed entry carries one to three events.
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.count != 2'd0))
        else $error("empty entry pushed");

    // Drain index stays inside the head entry.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (ev_idx < head.count))
        else $error("drain index beyond entry");

    // A pop completes an event run: the next output carries run_end.
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid && m_tlast))
        else $error("entry popped without last event");

endmodule
